@@ hw/rtl/smm_pkg.sv @@
// Shared constants, types and arithmetic helpers of the streaming matrix multiplier.
package smm_pkg;

  // Default array limits; the top level takes them as parameters.
  localparam int unsigned MAX_INNER_DEF = 8;
  localparam int unsigned MAX_COLS_DEF  = 8;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned B_INDEX_W  = 6;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COL_OUT_W  = 3;
  localparam int unsigned SIZE_W     = 4;

  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 56;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS   = 2'd2;

  // Input item kinds.
  localparam logic OP_WRITE_B  = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

  // Control shared by every cell of the accumulator chain.
  typedef struct packed {
    logic load;   // capture rescaled sum into the hold register, clear accumulator
    logic shift;  // move hold registers one cell toward the output
  } smm_cell_ctrl_t;

  function automatic logic signed [ACC_W-1:0] smm_sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] sum;
    sum = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (sum[ACC_W-1] != a[ACC_W-1])) begin
      sum = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return sum;
  endfunction

  // Q32.32 to Q16.16: floor shift by 16, then clip to 32 bits.
  function automatic logic signed [VALUE_W-1:0] smm_rescale(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [VALUE_W-1:0] q;
    if ((&acc[ACC_W-1:47]) || !(|acc[ACC_W-1:47])) begin
      q = acc[47:16];
    end else if (acc[ACC_W-1]) begin
      q = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      q = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    return q;
  endfunction

endpackage

@@ hw/rtl/smm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/smm_cell.sv @@
// One column cell: saturating accumulator, token pass-through and output hold register.
module smm_cell #(
  parameter int unsigned ColW   = 3,
  parameter int unsigned ColIdx = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  smm_pkg::smm_cell_ctrl_t               ctrl_i,
  input  logic                                  tok_valid_i,
  input  logic [ColW-1:0]                       tok_col_i,
  input  logic signed [smm_pkg::ACC_W-1:0]      tok_prod_i,
  output logic                                  tok_valid_o,
  output logic [ColW-1:0]                       tok_col_o,
  output logic signed [smm_pkg::ACC_W-1:0]      tok_prod_o,
  input  logic signed [smm_pkg::VALUE_W-1:0]    hold_i,
  output logic signed [smm_pkg::VALUE_W-1:0]    hold_o
);
  import smm_pkg::*;

  logic                      tok_valid_q;
  logic [ColW-1:0]           tok_col_q;
  logic signed [ACC_W-1:0]   tok_prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [VALUE_W-1:0] hold_q;
  logic                      hit;

  assign hit = tok_valid_i && (tok_col_i == ColW'(ColIdx));

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = '0;
    end else if (hit) begin
      acc_d = smm_sat_add(acc_q, tok_prod_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      tok_valid_q <= tok_valid_i;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_col_q  <= tok_col_i;
    tok_prod_q <= tok_prod_i;
    if (ctrl_i.load) begin
      hold_q <= smm_rescale(acc_q);
    end else if (ctrl_i.shift) begin
      hold_q <= hold_i;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_col_o   = tok_col_q;
  assign tok_prod_o  = tok_prod_q;
  assign hold_o      = hold_q;

endmodule

@@ hw/rtl/streaming_matrix_multiply.sv @@
// Streaming matrix multiply: B store, sequencer, product stage and column cell chain.
// Sequence: a B write goes straight into the store. An A element passes through the accepting
// cycle, one B read per column of the effective out_cols, a drain state while the products
// ripple down the cell chain, then a closing state. Closing a row waits while the previous
// row is still being shown; results leave one per cycle while m_axis_tready is high, from the
// next cycle. Reset clears counters and accumulators and sets the sizes to 2, not the B store.
module streaming_matrix_multiply #(
  parameter int unsigned MAX_INNER = smm_pkg::MAX_INNER_DEF,
  parameter int unsigned MAX_COLS  = smm_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [smm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [5:0] b_index, [37:6] value, [39:38] zero
  input  logic [smm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] op
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] product, [47:32] row_index, [50:48] col_index, [55:51] zero
  output logic [smm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // last_in_row
  output logic                            m_axis_tlast,
  // [0] last_of_matrix
  output logic [0:0]                      m_axis_tuser
);
  import smm_pkg::*;

  localparam int unsigned Depth = MAX_INNER * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned IW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned ISW   = $clog2(MAX_INNER + 1);
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CSW   = $clog2(MAX_COLS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Configuration registers
  logic [SIZE_W-1:0] inner_size_q, out_cols_q;
  logic [ROW_W-1:0]  out_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_size_q <= SIZE_W'(2);
      out_cols_q   <= SIZE_W'(2);
      out_rows_q   <= ROW_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i[SIZE_W-1:0];
        CFG_OUT_COLS:   out_cols_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_OUT_ROWS:   out_rows_q   <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ISW-1:0]   inner_eff;
  logic [CSW-1:0]   cols_eff;
  logic [ROW_W-1:0] rows_eff;

  always_comb begin
    if (inner_size_q == '0)             inner_eff = ISW'(1);
    else if (inner_size_q > MAX_INNER)  inner_eff = ISW'(MAX_INNER);
    else                                inner_eff = ISW'(inner_size_q);
    if (out_cols_q == '0)               cols_eff = CSW'(1);
    else if (out_cols_q > MAX_COLS)     cols_eff = CSW'(MAX_COLS);
    else                                cols_eff = CSW'(out_cols_q);
    rows_eff = (out_rows_q == '0) ? ROW_W'(1) : out_rows_q;
  end

  // Input decode
  logic                      s_fire;
  logic                      in_op;
  logic [B_INDEX_W-1:0]      in_b_index;
  logic signed [VALUE_W-1:0] in_value;

  assign in_op      = s_axis_tuser[0];
  assign in_b_index = s_axis_tdata[B_INDEX_W-1:0];
  assign in_value   = s_axis_tdata[B_INDEX_W+VALUE_W-1:B_INDEX_W];
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  // Sequencer state
  logic [1:0]                state_q, state_d;
  logic signed [VALUE_W-1:0] a_q, a_d;
  logic [AW-1:0]             base_q, base_d;
  logic [CW-1:0]             j_q, j_d;
  logic [CSW-1:0]            cols_q, cols_d;
  logic [ISW-1:0]            inner_q, inner_d;
  logic [CSW-1:0]            drain_q, drain_d;
  logic [IW-1:0]             inner_cnt_q, inner_cnt_d;
  logic [ROW_W-1:0]          row_cnt_q, row_cnt_d;

  // Output side
  logic                      out_busy_q, out_busy_d;
  logic [CW-1:0]             out_j_q, out_j_d;
  logic [CSW-1:0]            out_ncols_q, out_ncols_d;
  logic [ROW_W-1:0]          out_row_q, out_row_d;
  logic                      out_last_mat_q, out_last_mat_d;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [IW-1:0]             k_sel;
  logic                      last_row;
  logic                      m_fire, row_tail;
  smm_cell_ctrl_t            cell_ctrl;

  assign k_sel = (ISW'(inner_cnt_q) < inner_eff) ? inner_cnt_q : IW'(inner_eff - 1'b1);
  assign last_row = ({1'b0, row_cnt_q} + 17'd1) >= {1'b0, rows_eff};
  assign m_fire   = m_axis_tvalid && m_axis_tready;
  assign row_tail = (CSW'(out_j_q) + CSW'(1)) == out_ncols_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign ram_we    = s_fire && (in_op == OP_WRITE_B) && (32'(in_b_index) < Depth);
  assign ram_re    = (state_q == ST_FETCH);
  assign ram_raddr = AW'(base_q + AW'(j_q));

  always_comb begin
    state_d        = state_q;
    a_d            = a_q;
    base_d         = base_q;
    j_d            = j_q;
    cols_d         = cols_q;
    inner_d        = inner_q;
    drain_d        = drain_q;
    inner_cnt_d    = inner_cnt_q;
    row_cnt_d      = row_cnt_q;
    out_busy_d     = out_busy_q;
    out_j_d        = out_j_q;
    out_ncols_d    = out_ncols_q;
    out_row_d      = out_row_q;
    out_last_mat_d = out_last_mat_q;
    cell_ctrl      = '0;

    // Drain the finished row one transfer at a time
    if (m_fire) begin
      cell_ctrl.shift = 1'b1;
      if (row_tail) out_busy_d = 1'b0;
      else          out_j_d    = out_j_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (in_op == OP_STREAM_A)) begin
          a_d     = in_value;
          base_d  = AW'(k_sel) * AW'(cols_eff);
          j_d     = '0;
          cols_d  = cols_eff;
          inner_d = inner_eff;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if ((CSW'(j_q) + CSW'(1)) == cols_q) begin
          drain_d = cols_q;
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait until the last column's product has reached its cell
        if (drain_q == '0) state_d = ST_FIN;
        else               drain_d = drain_q - 1'b1;
      end
      ST_FIN: begin
        if ((ISW'(inner_cnt_q) + ISW'(1)) < inner_q) begin
          inner_cnt_d = inner_cnt_q + 1'b1;
          state_d     = ST_IDLE;
        end else if (!out_busy_q) begin
          cell_ctrl.load = 1'b1;
          inner_cnt_d    = '0;
          out_busy_d     = 1'b1;
          out_j_d        = '0;
          out_ncols_d    = cols_q;
          out_row_d      = row_cnt_q;
          out_last_mat_d = last_row;
          row_cnt_d      = last_row ? '0 : row_cnt_q + 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      cols_q      <= CSW'(1);
      inner_q     <= ISW'(1);
      drain_q     <= '0;
      inner_cnt_q <= '0;
      row_cnt_q   <= '0;
      out_busy_q  <= 1'b0;
      out_j_q     <= '0;
      out_ncols_q <= CSW'(1);
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      cols_q      <= cols_d;
      inner_q     <= inner_d;
      drain_q     <= drain_d;
      inner_cnt_q <= inner_cnt_d;
      row_cnt_q   <= row_cnt_d;
      out_busy_q  <= out_busy_d;
      out_j_q     <= out_j_d;
      out_ncols_q <= out_ncols_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q            <= a_d;
    base_q         <= base_d;
    out_row_q      <= out_row_d;
    out_last_mat_q <= out_last_mat_d;
  end

  // B store
  logic signed [VALUE_W-1:0] b_rdata;

  smm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (Depth)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_b_index)),
    .wdata_i (in_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (b_rdata)
  );

  // Product stage: read data and column arrive in the cycle after the issue
  logic                    rd_valid_q, p_valid_q;
  logic [CW-1:0]           rd_col_q, p_col_q;
  logic signed [ACC_W-1:0] mul, p_q;

  assign mul = a_q * b_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= ram_re;
      p_valid_q  <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q <= j_q;
    p_col_q  <= rd_col_q;
    p_q      <= mul;
  end

  // Column cell chain
  logic                      tok_valid [MAX_COLS+1];
  logic [CW-1:0]             tok_col   [MAX_COLS+1];
  logic signed [ACC_W-1:0]   tok_prod  [MAX_COLS+1];
  logic signed [VALUE_W-1:0] hold      [MAX_COLS+1];

  assign tok_valid[0]    = p_valid_q;
  assign tok_col[0]      = p_col_q;
  assign tok_prod[0]     = p_q;
  assign hold[MAX_COLS]  = '0;

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    smm_cell #(
      .ColW   (CW),
      .ColIdx (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .tok_valid_i (tok_valid[i]),
      .tok_col_i   (tok_col[i]),
      .tok_prod_i  (tok_prod[i]),
      .tok_valid_o (tok_valid[i+1]),
      .tok_col_o   (tok_col[i+1]),
      .tok_prod_o  (tok_prod[i+1]),
      .hold_i      (hold[i+1]),
      .hold_o      (hold[i])
    );
  end

  assign m_axis_tvalid   = out_busy_q;
  assign m_axis_tdata    = {5'b0, COL_OUT_W'(out_j_q), out_row_q, hold[0]};
  assign m_axis_tlast    = row_tail;
  assign m_axis_tuser[0] = row_tail && out_last_mat_q;

endmodule

@@ bench/streaming_matrix_multiply_tb.sv @@
// Self-checking bench for the streaming matrix multiplier: directed table, then random phases.
module streaming_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smm_pkg::*;

  localparam int unsigned B_DEPTH         = MAX_INNER_DEF * MAX_COLS_DEF;
  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned SETTLE_CYCLES   = 80;
  localparam int unsigned RANDOM_ITEMS    = 320;
  localparam int unsigned PRESSURE_AT     = 60;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned LIMIT_NS        = 40_000_000;
  localparam int unsigned N_DIR           = 29;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

  // One directed row: an input transfer or a register write, with optional known products.
  typedef struct packed {
    step_kind_e            kind;
    logic                  op;
    logic [B_INDEX_W-1:0]  b_idx;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [31:0]           value;
    logic [1:0]            n_typed;
    logic [31:0]           typed0;
    logic [31:0]           typed1;
  } dir_step_t;

  typedef struct packed {
    logic [31:0] product;
    logic [15:0] row;
    logic [2:0]  col;
    logic        last_in_row;
    logic        last_of_matrix;
  } c_elem_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;
  logic [0:0]             m_axis_tuser;

  // Shadow of the block: registers, B store, row accumulators, counters.
  logic [3:0]          reg_inner = 4'd2;
  logic [3:0]          reg_cols  = 4'd2;
  logic [15:0]         reg_rows  = 16'd2;
  logic signed [31:0]  b_mem [B_DEPTH];
  bit                  b_written [B_DEPTH];
  longint              row_acc [MAX_COLS_DEF];
  int unsigned         k_count = 0;
  int unsigned         r_count = 0;

  c_elem_t     c_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned tx_calm    = 0;

  dir_step_t dir_steps [N_DIR] = '{
    '{STEP_ITEM, OP_WRITE_B,  6'd0,  '0, 32'h0001_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd1,  '0, 32'h0002_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd2,  '0, 32'h0003_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd3,  '0, 32'h0004_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd63, '0, 32'h0001_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h0001_0000, 2'd2, 32'h0004_0000, 32'h0006_0000},
    '{STEP_ITEM, OP_STREAM_A, 6'd42, '0, 32'h7FFF_FFFF, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd21, '0, 32'h7FFF_FFFF, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd63, '0, 32'h8000_0000, 2'd2, 32'h8000_0000, 32'h8000_0000},
    '{STEP_ITEM, OP_STREAM_A, 6'd5,  '0, 32'h0000_0001, 2'd0, 32'h0, 32'h0},
    // B rewrite in the middle of a row
    '{STEP_ITEM, OP_WRITE_B,  6'd2,  '0, 32'hFFFF_FFFF, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd9,  '0, 32'h0000_0000, 2'd2, 32'h0000_0001, 32'h0000_0002},
    // negative sum rounds toward minus infinity
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'hFFFF_FFFF, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h0000_0001, 2'd2, 32'hFFFF_FFFE, 32'h0000_0002},
    '{STEP_CFG,  OP_WRITE_B,  6'd0,  CFG_INNER_SIZE, 32'd4, 2'd0, 32'h0, 32'h0},
    '{STEP_CFG,  OP_WRITE_B,  6'd0,  CFG_OUT_COLS,   32'd1, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd0,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd1,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd2,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_WRITE_B,  6'd3,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    // clamp the 64-bit sum at the top, then pull it back into range
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h8000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h7FFF_FFFF, 2'd0, 32'h0, 32'h0},
    '{STEP_ITEM, OP_STREAM_A, 6'd0,  '0, 32'h7FFF_FFFF, 2'd1, 32'h0000_FFFF, 32'h0},
    // sizes out of range and an unused register
    '{STEP_CFG,  OP_WRITE_B,  6'd0,  CFG_INNER_SIZE, 32'h0000_FFF0, 2'd0, 32'h0, 32'h0},
    '{STEP_CFG,  OP_WRITE_B,  6'd0,  CFG_OUT_COLS,   32'h0000_000F, 2'd0, 32'h0, 32'h0},
    '{STEP_CFG,  OP_WRITE_B,  6'd0,  CFG_OUT_ROWS,   32'h0000_0000, 2'd0, 32'h0, 32'h0},
    '{STEP_CFG,  OP_WRITE_B,  6'd0,  CFG_UNUSED,     32'h0000_5A5A, 2'd0, 32'h0, 32'h0}
  };

  streaming_matrix_multiply i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint acc_add_clamped(input longint a, input longint b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  // Q32.32 down to Q16.16: floor shift, then clip to 32 bits.
  function automatic logic [31:0] to_q16(input longint acc);
    longint q;
    q = acc >>> 16;
    if (q > Q16_MAX) return 32'h7FFF_FFFF;
    if (q < Q16_MIN) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2, 3: return $urandom;
      // roughly -8.0 .. +8.0
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Record a B write, or accumulate one A element against its B row; push the product row when it closes.
  task automatic predict_c_row(input logic op, input logic [B_INDEX_W-1:0] idx,
                               input logic signed [31:0] val);
    int unsigned inner, cols, rows, k;
    bit          last_row;
    c_elem_t     e;
    if (op == OP_WRITE_B) begin
      b_mem[idx] = val;
      return;
    end
    inner = clip_size(reg_inner, MAX_INNER_DEF);
    cols  = clip_size(reg_cols, MAX_COLS_DEF);
    rows  = (reg_rows == 0) ? 1 : reg_rows;
    k     = (k_count < inner) ? k_count : inner - 1;
    for (int unsigned j = 0; j < cols; j++) begin
      row_acc[j] = acc_add_clamped(row_acc[j], longint'(val) * longint'(b_mem[k * cols + j]));
    end
    if (k_count + 1 < inner) begin
      k_count++;
      return;
    end
    last_row = (r_count + 1 >= rows);
    for (int unsigned j = 0; j < cols; j++) begin
      e.product        = to_q16(row_acc[j]);
      e.row            = 16'(r_count);
      e.col            = 3'(j);
      e.last_in_row    = (j + 1 == cols);
      e.last_of_matrix = last_row && (j + 1 == cols);
      c_due.push_back(e);
    end
    for (int unsigned j = 0; j < MAX_COLS_DEF; j++) row_acc[j] = 0;
    k_count = 0;
    r_count = last_row ? 0 : ((r_count + 1) & 32'hFFFF);
  endtask

  task automatic send_item(input logic op, input logic [B_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (op == OP_WRITE_B) b_written[idx] = 1'b1;
    predict_c_row(op, idx, val);
  endtask

  task automatic sender_pause();
    int unsigned n;
    if (tx_calm > 0) begin
      tx_calm--;
      return;
    end
    if ($urandom_range(0, 24) == 0) begin
      tx_calm = $urandom_range(8, 30);
      return;
    end
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_and_pause(input logic op, input logic [B_INDEX_W-1:0] idx,
                                input logic [31:0] val);
    send_item(op, idx, val);
    sender_pause();
  endtask

  // Write every B entry the current sizes can reach that has not been written yet.
  task automatic fill_b_rows();
    int unsigned inner, cols;
    inner = clip_size(reg_inner, MAX_INNER_DEF);
    cols  = clip_size(reg_cols, MAX_COLS_DEF);
    for (int unsigned bi = 0; bi < inner * cols; bi++) begin
      if (!b_written[bi]) send_and_pause(OP_WRITE_B, 6'(bi), rand_value());
    end
  endtask

  // Drain all outstanding products, then let in-flight A elements finish.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (c_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_INNER_SIZE: reg_inner = data[3:0];
      CFG_OUT_COLS:   reg_cols  = data[3:0];
      CFG_OUT_ROWS:   reg_rows  = data;
      default: ;
    endcase
  endtask

  task automatic run_directed();
    dir_step_t st;
    c_elem_t   e;
    bit        in_cfg;
    int        base;
    in_cfg = 1'b0;
    for (int i = 0; i < N_DIR; i++) begin
      st = dir_steps[i];
      if (st.kind == STEP_CFG) begin
        if (!in_cfg) settle_block();
        in_cfg = 1'b1;
        write_reg(st.reg_idx, st.value[15:0]);
      end else begin
        in_cfg = 1'b0;
        if (st.op == OP_STREAM_A) fill_b_rows();
        send_item(st.op, st.b_idx, st.value);
        // known products replace the predicted ones for this row
        base = c_due.size() - st.n_typed;
        for (int t = 0; t < st.n_typed; t++) begin
          e = c_due[base + t];
          e.product = (t == 0) ? st.typed0 : st.typed1;
          c_due[base + t] = e;
        end
        sender_pause();
      end
    end
  endtask

  function automatic int unsigned rand_size();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 15);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [15:0] rand_rows();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic configure_phase(input int unsigned p);
    settle_block();
    case (p)
      0: begin
        write_reg(CFG_INNER_SIZE, 16'd1);
        write_reg(CFG_OUT_COLS, 16'd1);
        write_reg(CFG_OUT_ROWS, 16'd1);
      end
      1: begin
        write_reg(CFG_INNER_SIZE, 16'd8);
        write_reg(CFG_OUT_COLS, 16'd8);
        write_reg(CFG_OUT_ROWS, 16'hFFFF);
      end
      2: begin
        write_reg(CFG_INNER_SIZE, {12'($urandom), 4'd0});
        write_reg(CFG_OUT_COLS, {12'($urandom), 4'd15});
        write_reg(CFG_OUT_ROWS, 16'd0);
        write_reg(CFG_UNUSED, 16'($urandom));
      end
      3: begin
        write_reg(CFG_INNER_SIZE, 16'd15);
        write_reg(CFG_OUT_COLS, 16'd0);
        write_reg(CFG_OUT_ROWS, 16'd3);
      end
      default: begin
        // leave some registers as they are; counters carry over
        if ($urandom_range(0, 3) != 0) write_reg(CFG_INNER_SIZE, {12'($urandom), 4'(rand_size())});
        if ($urandom_range(0, 3) != 0) write_reg(CFG_OUT_COLS, {12'($urandom), 4'(rand_size())});
        if ($urandom_range(0, 3) != 0) write_reg(CFG_OUT_ROWS, rand_rows());
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom));
      end
    endcase
  endtask

  // Receiving side: check each transfer, then pick the next ready level.
  initial begin
    int unsigned hold_left;
    int unsigned rx_calm;
    bit          pressure_done;
    c_elem_t     got, want;
    hold_left     = 0;
    rx_calm       = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.product        = m_axis_tdata[31:0];
        got.row            = m_axis_tdata[47:32];
        got.col            = m_axis_tdata[50:48];
        got.last_in_row    = m_axis_tlast;
        got.last_of_matrix = m_axis_tuser[0];
        if (c_due.size() == 0) begin
          note_mismatch("unexpected product", got.product, 0);
        end else begin
          want = c_due.pop_front();
          if (got.product != want.product) note_mismatch("product", got.product, want.product);
          if (got.row != want.row) note_mismatch("row_index", got.row, want.row);
          if (got.col != want.col) note_mismatch("col_index", got.col, want.col);
          if (got.last_in_row != want.last_in_row)
            note_mismatch("last_in_row", got.last_in_row, want.last_in_row);
          if (got.last_of_matrix != want.last_of_matrix)
            note_mismatch("last_of_matrix", got.last_of_matrix, want.last_of_matrix);
        end
      end
      // hold off long enough that the block backs up into its input
      if (!pressure_done && items_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES;
      end else if (hold_left == 0) begin
        if (rx_calm > 0) begin
          rx_calm--;
        end else if ($urandom_range(0, 99) == 0) begin
          rx_calm = $urandom_range(30, 120);
        end else begin
          hold_left = gap_len();
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned start_count;
    int unsigned phase;
    int unsigned n_items;
    for (int i = 0; i < B_DEPTH; i++) begin
      b_mem[i]     = '0;
      b_written[i] = 1'b0;
    end
    for (int j = 0; j < MAX_COLS_DEF; j++) row_acc[j] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      configure_phase(phase);
      phase++;
      n_items = $urandom_range(12, 40);
      repeat (n_items) begin
        if ($urandom_range(0, 9) == 0) begin
          send_and_pause(OP_WRITE_B, 6'($urandom), rand_value());
        end else begin
          fill_b_rows();
          send_and_pause(OP_STREAM_A, 6'($urandom), rand_value());
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (c_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && c_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
